// ===== sv/ecl_pkg.sv =====
// Shared types and constants for the escape-coded LZ decoder.
// No dependencies; the other files that use this package refer to it by scoped names.
`default_nettype none

package ecl_pkg;

  // Input word kinds.
  localparam logic [1:0] KIND_DICT   = 2'd0;
  localparam logic [1:0] KIND_PACKED = 2'd1;
  localparam logic [1:0] KIND_DRAIN  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ESCAPE_CODE    = 3'd0;
  localparam logic [2:0] REG_LENGTH_PAGES   = 3'd1;
  localparam logic [2:0] REG_OFF_PAGE_CNT   = 3'd2;
  localparam logic [2:0] REG_ESCAPE_IN_DATA = 3'd3;
  localparam logic [2:0] REG_LIT_ESC_LENGTH = 3'd4;
  localparam logic [2:0] REG_MIN_LENGTH     = 3'd5;

  // Width of a decoded length and of a copy distance.
  localparam int LEN_W  = 17;
  localparam int DIST_W = 18;

  // Depth of the output queue.
  localparam int OQ_DEPTH = 3;

  // What one accepted word leaves for the write-back stage.
  typedef struct packed {
    logic       wr;        // append a byte to the history
    logic       src_ram;   // the byte comes from the history read data
    logic [7:0] data;      // the byte when it does not come from the RAM
    logic       ov;        // the result carries a decoded byte
    logic       pending;   // copy bytes remain after this word
    logic       err;       // the token just finished reaches too far back
  } s1_info_t;

  // One result word.
  typedef struct packed {
    logic       err;
    logic       pending;
    logic       ov;
    logic [7:0] out_byte;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/ecl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module ecl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the entry being written sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ecl_outq.sv =====
// Three-entry output queue that decouples the write-back stage from the result stream.
// Depends on ecl_pkg for the result word type and the queue depth.
`default_nettype none

module ecl_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ecl_pkg::res_t push_res,
  output logic [1:0]         count,
  output logic               m_valid,
  input  wire logic          m_ready,
  output ecl_pkg::res_t      m_res
);

  ecl_pkg::res_t slots [ecl_pkg::OQ_DEPTH];
  logic [1:0] head;
  logic [1:0] tail;
  logic       pop;

  assign pop     = m_valid && m_ready;
  assign m_valid = (count != 2'd0);
  assign m_res   = slots[head];

  // Slot storage; the producer never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_res;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == 2'(ecl_pkg::OQ_DEPTH - 1)) ? 2'd0 : tail + 2'd1;
      end
      if (pop) begin
        head <= (head == 2'(ecl_pkg::OQ_DEPTH - 1)) ? 2'd0 : head + 2'd1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ecl_ctrl.sv =====
// Token decoder and history bookkeeping: configuration registers, token phase,
// write pointer, fill count, held length and distance, and the copy counter.
// Depends on ecl_pkg.
`default_nettype none

module ecl_ctrl #(
  parameter int HISTORY_DEPTH = 131072
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [7:0]                       cfg_data,
  input  wire logic                             accept,
  input  wire logic [1:0]                       kind,
  input  wire logic [7:0]                       data_byte,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
  output logic                                  rd_en,
  output ecl_pkg::s1_info_t                     info
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = (FW > ecl_pkg::DIST_W) ? FW : ecl_pkg::DIST_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_LEN2,
    PH_OFF,
    PH_OFF2
  } phase_t;

  // Configuration registers.
  logic [7:0] escape_code;
  logic [7:0] length_pages;
  logic [7:0] off_page_cnt;
  logic       escape_in_data;
  logic [7:0] literal_escape_length;
  logic [7:0] min_length;

  // Decoder state.
  phase_t                      phase, phase_next;
  logic [AW-1:0]               wp, wp_next;
  logic [FW-1:0]               filled, filled_next;
  logic [ecl_pkg::LEN_W-1:0]   held_length, held_length_next;
  logic [ecl_pkg::DIST_W-1:0]  held_offset, held_offset_next;
  logic [ecl_pkg::LEN_W-1:0]   remaining, remaining_next;

  // Field arithmetic.
  logic [7:0]                  top_v;
  logic [8:0]                  low_v;
  logic [8:0]                  olow_v;
  logic                        len_paged;
  logic [ecl_pkg::LEN_W-1:0]   len_page_val;
  logic [ecl_pkg::LEN_W-1:0]   len_direct;
  logic [ecl_pkg::LEN_W-1:0]   len_second;
  logic [ecl_pkg::DIST_W-1:0]  off_page_val;
  logic [ecl_pkg::DIST_W-1:0]  off_second;
  logic [ecl_pkg::DIST_W-1:0]  fin_off;
  logic [ecl_pkg::DIST_W-1:0]  reach;
  logic                        too_far;
  logic [CW:0]                 back_diff;
  logic [CW:0]                 back_idx;
  logic                        push_en;
  logic [7:0]                  push_byte;
  logic                        finish;

  assign top_v        = escape_in_data ? 8'd254 : 8'd255;
  assign low_v        = {1'b0, top_v} + 9'd1 - {1'b0, length_pages};
  assign olow_v       = 9'd256 - {1'b0, off_page_cnt};
  assign len_paged    = (length_pages != 8'd0) && ({1'b0, data_byte} >= low_v) &&
                        (data_byte <= top_v);
  assign len_page_val = ecl_pkg::LEN_W'(low_v) + {1'b0, top_v - data_byte, 8'h00};
  assign len_direct   = ecl_pkg::LEN_W'(data_byte) + ecl_pkg::LEN_W'(min_length);
  assign len_second   = held_length + ecl_pkg::LEN_W'(data_byte) +
                        ecl_pkg::LEN_W'(min_length);
  assign off_page_val = ecl_pkg::DIST_W'(olow_v) +
                        ecl_pkg::DIST_W'({8'd255 - data_byte, 8'h00});
  assign off_second   = held_offset + ecl_pkg::DIST_W'(data_byte);
  assign fin_off      = (phase == PH_OFF2) ? off_second : ecl_pkg::DIST_W'(data_byte);
  assign reach        = fin_off + ecl_pkg::DIST_W'(held_length);
  assign too_far      = CW'(reach) > CW'(filled);

  // Copy source: write pointer minus the held distance, wrapped into the ring.
  assign back_diff = (CW + 1)'(wp) - (CW + 1)'(held_offset);
  assign back_idx  = back_diff[CW] ? back_diff + (CW + 1)'(HISTORY_DEPTH) : back_diff;
  assign rd_addr   = back_idx[AW-1:0];
  assign wr_addr   = wp;

  // Next state for one accepted word.
  always_comb begin
    phase_next       = phase;
    held_length_next = held_length;
    held_offset_next = held_offset;
    remaining_next   = remaining;
    push_en          = 1'b0;
    push_byte        = data_byte;
    finish           = 1'b0;
    rd_en            = 1'b0;
    info             = '0;

    if (accept) begin
      case (kind)
        ecl_pkg::KIND_DICT: begin
          push_en = 1'b1;
        end
        ecl_pkg::KIND_PACKED: begin
          if (remaining == '0) begin
            case (phase)
              PH_IDLE: begin
                if (data_byte == escape_code) begin
                  phase_next = PH_LEN;
                end else begin
                  push_en = 1'b1;
                  info.ov = 1'b1;
                end
              end
              PH_LEN: begin
                if (escape_in_data && (data_byte == literal_escape_length)) begin
                  push_en    = 1'b1;
                  push_byte  = escape_code;
                  info.ov    = 1'b1;
                  phase_next = PH_IDLE;
                end else if (len_paged) begin
                  held_length_next = len_page_val;
                  phase_next       = PH_LEN2;
                end else begin
                  held_length_next = len_direct;
                  phase_next       = PH_OFF;
                end
              end
              PH_LEN2: begin
                held_length_next = len_second;
                phase_next       = PH_OFF;
              end
              PH_OFF: begin
                if ({1'b0, data_byte} >= olow_v) begin
                  held_offset_next = off_page_val;
                  phase_next       = PH_OFF2;
                end else begin
                  phase_next = PH_IDLE;
                  finish     = 1'b1;
                end
              end
              PH_OFF2: begin
                phase_next = PH_IDLE;
                finish     = 1'b1;
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
        ecl_pkg::KIND_DRAIN: begin
          if (remaining != '0) begin
            push_en        = 1'b1;
            rd_en          = 1'b1;
            info.src_ram   = 1'b1;
            info.ov        = 1'b1;
            remaining_next = remaining - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Token completion: start the copy, drop an empty one, or flag a reach too far back.
    if (finish) begin
      remaining_next = '0;
      if (held_length == '0) begin
        held_offset_next = fin_off;
      end else if (too_far) begin
        held_offset_next = '0;
        info.err         = 1'b1;
      end else begin
        held_offset_next = reach;
        remaining_next   = held_length;
      end
    end

    info.wr      = push_en;
    info.data    = (push_en && !info.src_ram) ? push_byte : 8'h00;
    info.pending = (remaining_next != '0);

    wp_next     = wp;
    filled_next = filled;
    if (push_en) begin
      wp_next = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (filled != FW'(HISTORY_DEPTH)) begin
        filled_next = filled + 1'b1;
      end
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code           <= 8'd0;
      length_pages          <= 8'd0;
      off_page_cnt          <= 8'd0;
      escape_in_data        <= 1'b1;
      literal_escape_length <= 8'd255;
      min_length            <= 8'd3;
      phase                 <= PH_IDLE;
      wp                    <= '0;
      filled                <= '0;
      held_length           <= '0;
      held_offset           <= '0;
      remaining             <= '0;
    end else begin
      phase       <= phase_next;
      wp          <= wp_next;
      filled      <= filled_next;
      held_length <= held_length_next;
      held_offset <= held_offset_next;
      remaining   <= remaining_next;
      if (cfg_we) begin
        case (cfg_index)
          ecl_pkg::REG_ESCAPE_CODE:    escape_code           <= cfg_data;
          ecl_pkg::REG_LENGTH_PAGES:   length_pages          <= cfg_data;
          ecl_pkg::REG_OFF_PAGE_CNT:   off_page_cnt          <= cfg_data;
          ecl_pkg::REG_ESCAPE_IN_DATA: escape_in_data        <= cfg_data[0];
          ecl_pkg::REG_LIT_ESC_LENGTH: literal_escape_length <= cfg_data;
          ecl_pkg::REG_MIN_LENGTH:     min_length            <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/escape_coded_lz_decoder.sv =====
// Top level of the escape-coded LZ decoder: decode stage, history RAM with a
// write-back stage and forwarding, and the output queue.
// Depends on ecl_pkg, ecl_ctrl, ecl_ram and ecl_outq.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  tdata: data_byte; tuser: kind
//   m_*      out        m_tvalid/m_tready  tdata: out_byte, flags; tuser: out_valid
//   cfg_*    in         cfg_we             cfg_index selects, cfg_data is written
//
// Each input word yields one result word via the write-back stage and output queue; one
// word per cycle is sustained while m_tready stays high. The history RAM is read when a
// drain word is taken and written back in the following cycle, so a copy one byte back
// is served by forwarding. Input stalls while the write-back stage and the output queue
// hold three words together. Reset is synchronous; the history RAM is not cleared.
`default_nettype none

module escape_coded_lz_decoder #(
  parameter int HISTORY_DEPTH = 131072
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
  input  wire logic [1:0]  s_tuser,    // [1:0] kind
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,    // [7:0] out_byte, [8] copy_pending, [9] distance_error
  output logic [0:0]       m_tuser     // [0] out_valid
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic                accept;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic                rd_en;
  ecl_pkg::s1_info_t   info;
  ecl_pkg::s1_info_t   info_fwd;

  // Write-back stage.
  logic                s1_valid;
  ecl_pkg::s1_info_t   s1_info;
  logic [AW-1:0]       s1_addr;
  logic [7:0]          ram_rdata;
  logic [7:0]          cur_byte;

  ecl_pkg::res_t       res;
  ecl_pkg::res_t       m_res;
  logic [1:0]          q_count;

  assign s_tready = ({1'b0, q_count} + {2'b00, s1_valid}) < 3'(ecl_pkg::OQ_DEPTH);
  assign accept   = s_tvalid && s_tready;

  ecl_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (s_tuser),
    .data_byte (s_tdata),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .rd_en     (rd_en),
    .info      (info)
  );

  // Byte written back this cycle: from the RAM for a copy unless it was forwarded.
  assign cur_byte = s1_info.src_ram ? ram_rdata : s1_info.data;

  // A copy that reads the entry being written back takes that byte directly.
  always_comb begin
    info_fwd = info;
    if (rd_en && s1_valid && s1_info.wr && (s1_addr == rd_addr)) begin
      info_fwd.src_ram = 1'b0;
      info_fwd.data    = cur_byte;
    end
  end

  ecl_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (s1_valid && s1_info.wr),
    .waddr (s1_addr),
    .wdata (cur_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Write-back stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_info <= info_fwd;
    s1_addr <= wr_addr;
  end

  // Result word from the write-back stage.
  always_comb begin
    res.out_byte = s1_info.ov ? cur_byte : 8'h00;
    res.ov       = s1_info.ov;
    res.pending  = s1_info.pending;
    res.err      = s1_info.err;
  end

  ecl_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_res (res),
    .count    (q_count),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata    = {6'b000000, m_res.err, m_res.pending, m_res.out_byte};
  assign m_tuser[0] = m_res.ov;

endmodule

`default_nettype wire

// ===== tb/ecl_stream_checker.sv =====
// Scoreboard for the escape-coded LZ decoder: follows register writes and input
// words, predicts each result word and compares it with the result stream.
// Depends on ecl_pkg for the word kinds and register indexes.
module ecl_stream_checker #(
  parameter int HISTORY_DEPTH = 131072
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic [1:0]  s_tuser,    // [1:0] kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // [7:0] out_byte, [8] copy_pending, [9] distance_error
  input  logic [0:0]  m_tuser,    // [0] out_valid
  output int          fail_count,
  output int          open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    TOK_IDLE, TOK_LEN, TOK_LEN_LO, TOK_OFF, TOK_OFF_LO
  } tok_state_t;

  typedef struct packed {
    logic       dist_err;
    logic       pending;
    logic       valid;
    logic [7:0] data;
  } decoded_t;

  // Private copy of the decoder state and its registers.
  logic [7:0]  ring [HISTORY_DEPTH];
  int unsigned wr_ptr;
  int unsigned fill_cnt;
  int unsigned copy_len;
  int unsigned copy_dist;
  int unsigned copy_left;
  tok_state_t  tok;
  logic [7:0]  esc_code;
  logic [7:0]  len_pages;
  logic [7:0]  off_pages;
  logic        esc_literal_en;
  logic [7:0]  lit_esc_len;
  logic [7:0]  len_bias;

  decoded_t    expected_words[$];
  int          mism = 0;

  // Appends one byte to the history ring; the fill level saturates at the depth.
  function automatic void append_byte(input logic [7:0] b);
    ring[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
    if (fill_cnt < HISTORY_DEPTH) fill_cnt++;
  endfunction

  // Ends a token: arms the copy, or drops it when it is empty or reaches past the history.
  function automatic logic close_token();
    int unsigned span;
    span = copy_dist + copy_len;
    if (copy_len == 0) begin
      copy_left = 0;
      return 1'b0;
    end
    if (span > fill_cnt) begin
      copy_left = 0;
      copy_dist = 0;
      return 1'b1;
    end
    copy_dist = span;
    copy_left = copy_len;
    return 1'b0;
  endfunction

  // Advances the private state by one input word and returns the result word.
  function automatic decoded_t decode_word(input logic [1:0] kind, input logic [7:0] b);
    decoded_t    r;
    int          top;
    int          low;
    int          olow;
    int unsigned src;
    r = '0;
    top = esc_literal_en ? 254 : 255;
    low = top + 1 - int'(len_pages);
    olow = 256 - int'(off_pages);
    if (kind == ecl_pkg::KIND_DICT) begin
      append_byte(b);
    end else if (kind == ecl_pkg::KIND_PACKED && copy_left == 0) begin
      case (tok)
        TOK_IDLE: begin
          if (b == esc_code) begin
            tok = TOK_LEN;
          end else begin
            r.data = b;
            r.valid = 1'b1;
            append_byte(b);
          end
        end
        TOK_LEN: begin
          if (esc_literal_en && b == lit_esc_len) begin
            // Escaped escape: the escape byte itself is the output.
            r.data = esc_code;
            r.valid = 1'b1;
            append_byte(esc_code);
            tok = TOK_IDLE;
          end else if (len_pages != 0 && b >= low && b <= top) begin
            copy_len = low + (top - int'(b)) * 256;
            tok = TOK_LEN_LO;
          end else begin
            copy_len = b + len_bias;
            tok = TOK_OFF;
          end
        end
        TOK_LEN_LO: begin
          copy_len = copy_len + b + len_bias;
          tok = TOK_OFF;
        end
        TOK_OFF: begin
          if (b >= olow) begin
            copy_dist = olow + (255 - int'(b)) * 256;
            tok = TOK_OFF_LO;
          end else begin
            copy_dist = b;
            tok = TOK_IDLE;
            r.dist_err = close_token();
          end
        end
        TOK_OFF_LO: begin
          copy_dist = copy_dist + b;
          tok = TOK_IDLE;
          r.dist_err = close_token();
        end
        default: tok = TOK_IDLE;
      endcase
    end else if (kind == ecl_pkg::KIND_DRAIN && copy_left != 0) begin
      src = (wr_ptr + HISTORY_DEPTH - (copy_dist % (HISTORY_DEPTH + 1))) % HISTORY_DEPTH;
      r.data = ring[src];
      r.valid = 1'b1;
      append_byte(r.data);
      copy_left--;
    end
    r.pending = (copy_left != 0);
    return r;
  endfunction

  // Reports the first few mismatches in full and counts all of them.
  function automatic void report(input string why, input decoded_t want, input decoded_t got);
    mism++;
    if (mism <= 10)
      $display("%t mismatch (%s): expected byte %02h valid %0b pending %0b error %0b,",
               $realtime, why, want.data, want.valid, want.pending, want.dist_err,
               " got byte %02h valid %0b pending %0b error %0b",
               got.data, got.valid, got.pending, got.dist_err);
  endfunction

  // Results are compared first; a word taken in the same cycle cannot be due yet.
  always @(posedge clk) begin : monitor
    decoded_t got;
    decoded_t want;
    if (rst) begin
      wr_ptr = 0;
      fill_cnt = 0;
      copy_len = 0;
      copy_dist = 0;
      copy_left = 0;
      tok = TOK_IDLE;
      esc_code = 8'd0;
      len_pages = 8'd0;
      off_pages = 8'd0;
      esc_literal_en = 1'b1;
      lit_esc_len = 8'd255;
      len_bias = 8'd3;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{dist_err: m_tdata[9], pending: m_tdata[8], valid: m_tuser[0],
                data: m_tdata[7:0]};
        if (expected_words.size() == 0) begin
          report("no result expected", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) report("wrong field", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ecl_pkg::REG_ESCAPE_CODE:    esc_code = cfg_data;
          ecl_pkg::REG_LENGTH_PAGES:   len_pages = cfg_data;
          ecl_pkg::REG_OFF_PAGE_CNT:   off_pages = cfg_data;
          ecl_pkg::REG_ESCAPE_IN_DATA: esc_literal_en = cfg_data[0];
          ecl_pkg::REG_LIT_ESC_LENGTH: lit_esc_len = cfg_data;
          ecl_pkg::REG_MIN_LENGTH:     len_bias = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_words.push_back(decode_word(s_tuser, s_tdata));
    end
    fail_count <= mism;
    open_count <= expected_words.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the escape-coded LZ decoder testbench: clock, reset, register setups,
// token-structured input stimulus, result back-pressure and the verdict.
// Depends on ecl_pkg, escape_coded_lz_decoder and ecl_stream_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 131072;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;     // [7:0] data_byte
  logic [1:0]  s_tuser = '0;     // [1:0] kind
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;          // [7:0] out_byte, [8] copy_pending, [9] distance_error
  logic [0:0]  m_tuser;          // [0] out_valid
  int          fail_count;
  int          open_count;

  // Register setups after the reset one, in register index order.
  logic [2:0] reg_ids [6] = '{ecl_pkg::REG_ESCAPE_CODE, ecl_pkg::REG_LENGTH_PAGES,
                              ecl_pkg::REG_OFF_PAGE_CNT, ecl_pkg::REG_ESCAPE_IN_DATA,
                              ecl_pkg::REG_LIT_ESC_LENGTH, ecl_pkg::REG_MIN_LENGTH};
  logic [7:0] setups [5][6] = '{
    '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
    '{8'h5A, 8'h04, 8'h02, 8'h01, 8'h10, 8'hFF},
    '{8'h80, 8'h10, 8'h80, 8'h01, 8'h00, 8'h01},
    '{8'h00, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h02},
    '{8'h33, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h00}
  };
  int budgets [6] = '{140, 110, 190, 140, 140, 140};

  // Stimulus view of the registers, used only to build tokens.
  logic [7:0] cur_esc = 8'd0;
  logic [7:0] cur_lpages = 8'd0;
  logic [7:0] cur_opages = 8'd0;
  logic       cur_eid = 1'b1;
  logic [7:0] cur_litlen = 8'd255;
  logic [7:0] cur_minl = 8'd3;

  int  hist_len = 0;
  int  fed = 0;
  bit  calm = 1'b0;
  int  rdy_left = 0;
  int  idle_cycles = 0;

  escape_coded_lz_decoder #(.HISTORY_DEPTH(DEPTH)) uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  ecl_stream_checker #(.HISTORY_DEPTH(DEPTH)) u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count, .open_count
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: random ready stretches and stalls, always ready in calm stretches.
  always @(posedge clk) begin
    if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      m_tready <= 1'b1;
      rdy_left <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b0;
      rdy_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("escape_coded_lz_decoder verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one word after a random gap and waits until it is taken.
  task automatic send(input logic [1:0] kind, input logic [7:0] b, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    if (counted) fed++;
  endtask

  // Holds the input until every expected result word has come out.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes every register of one setup while the decoder is idle.
  task automatic apply_setup(input int p);
    settle();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data <= setups[p][i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_esc = setups[p][0];
    cur_lpages = setups[p][1];
    cur_opages = setups[p][2];
    cur_eid = setups[p][3][0];
    cur_litlen = setups[p][4];
    cur_minl = setups[p][5];
  endtask

  // Sends one match token with mostly short lengths and reachable offsets, then
  // drains the copy with ignored packed words and dictionary words mixed in.
  task automatic send_token();
    int         top;
    int         low;
    int         olow;
    int         r;
    int         lval;
    int         oval;
    int         tlen;
    int         cap;
    int         t;
    int         n;
    logic [7:0] lb;
    logic [7:0] lb2;
    logic [7:0] ob;
    logic [7:0] ob2;
    bit         lit;
    bit         two_len;
    bit         two_off;
    top = cur_eid ? 254 : 255;
    low = top + 1 - int'(cur_lpages);
    olow = 256 - int'(cur_opages);
    r = $urandom_range(0, 99);
    if (cur_eid && r < 10) begin
      lb = cur_litlen;
    end else begin
      lb = (r < 88) ? 8'($urandom_range(0, 24)) : 8'($urandom_range(0, 255));
      // Two-byte lengths stay on the first page, except for a rare second page.
      if (r >= 98 && cur_lpages >= 2) lb = 8'(top - 1);
      else if (cur_lpages != 0 && lb >= low && lb <= top) lb = 8'(top);
    end
    lit = cur_eid && lb == cur_litlen;
    two_len = !lit && cur_lpages != 0 && lb >= low && lb <= top;
    send(ecl_pkg::KIND_PACKED, cur_esc, 1'b1);
    send(ecl_pkg::KIND_PACKED, lb, 1'b1);
    if (lit) begin
      hist_len++;
      return;
    end
    lval = lb;
    if (two_len) begin
      lb2 = (r < 88) ? 8'($urandom_range(0, 24)) : 8'($urandom_range(0, 255));
      send(ecl_pkg::KIND_PACKED, lb2, 1'b1);
      lval = low + (top - int'(lb)) * 256 + lb2;
    end
    tlen = lval + cur_minl;

    // Offset: usually a reachable one, sometimes any byte pair.
    if ($urandom_range(0, 99) < 85) begin
      cap = hist_len - tlen;
      if (cap < 0) cap = 0;
      if (cap > 300) cap = 300;
      t = $urandom_range(0, cap);
      if (t >= olow && (t - olow) / 256 > 255 - olow) t = olow - 1;
      two_off = (t >= olow);
      ob = two_off ? 8'(255 - (t - olow) / 256) : 8'(t);
      ob2 = 8'((t - olow) % 256);
      oval = t;
    end else begin
      ob = 8'($urandom_range(0, 255));
      ob2 = 8'($urandom_range(0, 255));
      two_off = (ob >= olow);
      oval = two_off ? olow + (255 - int'(ob)) * 256 + ob2 : ob;
    end
    send(ecl_pkg::KIND_PACKED, ob, 1'b1);
    if (two_off) send(ecl_pkg::KIND_PACKED, ob2, 1'b1);
    if (tlen == 0 || oval + tlen > hist_len) return;

    for (int i = 0; i < tlen; i++) begin
      n = $urandom_range(0, 99);
      if (n < 5) begin
        send(ecl_pkg::KIND_PACKED, 8'($urandom_range(0, 255)), 1'b0);
      end else if (n < 8) begin
        send(ecl_pkg::KIND_DICT, 8'($urandom_range(0, 255)), 1'b1);
        hist_len++;
      end
      send(ecl_pkg::KIND_DRAIN, 8'($urandom_range(0, 255)), 1'b1);
      hist_len++;
    end
  endtask

  // Random mix of literals, tokens and side words until the phase budget is used.
  task automatic run_random(input int budget);
    int         r;
    logic [7:0] b;
    fed = 0;
    while (fed < budget) begin
      r = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (r < 48) begin
        if (b == cur_esc) b = b ^ 8'h01;
        send(ecl_pkg::KIND_PACKED, b, 1'b1);
        hist_len++;
      end else if (r < 72) begin
        send_token();
      end else if (r < 82) begin
        send(ecl_pkg::KIND_DICT, b, 1'b1);
        hist_len++;
      end else if (r < 88) begin
        send(ecl_pkg::KIND_DRAIN, b, 1'b0);
      end else if (r < 92) begin
        send(KIND_UNUSED, b, 1'b0);
      end else if (r < 94) begin
        settle();
      end else begin
        calm <= !calm;
      end
    end
  endtask

  initial begin : stimulus
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset setup: escape 00, reserved length FF.
    send(ecl_pkg::KIND_DICT, 8'h00, 1'b1);
    send(ecl_pkg::KIND_DICT, 8'hFF, 1'b1);
    send(ecl_pkg::KIND_DICT, 8'hA5, 1'b1);
    send(ecl_pkg::KIND_DICT, 8'h5A, 1'b1);
    send(ecl_pkg::KIND_DICT, 8'h3C, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'hFF, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'h01, 1'b1);
    // Drain word with no copy pending, then an unused kind.
    send(ecl_pkg::KIND_DRAIN, 8'hFF, 1'b0);
    send(KIND_UNUSED, 8'hFF, 1'b0);
    // Escaped escape byte.
    send(ecl_pkg::KIND_PACKED, 8'h00, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'hFF, 1'b1);
    // Three-byte copy from five back, with a dictionary word and an ignored
    // packed word arriving while it is pending.
    send(ecl_pkg::KIND_PACKED, 8'h00, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'h00, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'h02, 1'b1);
    send(ecl_pkg::KIND_DICT, 8'h81, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'h00, 1'b0);
    repeat (3) send(ecl_pkg::KIND_DRAIN, 8'h00, 1'b1);
    send(ecl_pkg::KIND_DRAIN, 8'h00, 1'b0);
    // Token reaching far past the loaded history.
    send(ecl_pkg::KIND_PACKED, 8'h00, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'hFE, 1'b1);
    send(ecl_pkg::KIND_PACKED, 8'hFF, 1'b1);
    hist_len = 12;

    run_random(budgets[0]);
    for (int p = 0; p < 5; p++) begin
      apply_setup(p);
      n = $urandom_range(16, 40);
      repeat (n) begin
        send(ecl_pkg::KIND_DICT, 8'($urandom_range(0, 255)), 1'b1);
        hist_len++;
      end
      run_random(budgets[p + 1]);
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("escape_coded_lz_decoder verification clean");
    end else begin
      $display("escape_coded_lz_decoder verification failed");
    end
    $finish;
  end

endmodule
